// ===== rtl/ndq_pkg.sv =====
package ndq_pkg;

    localparam int TAPS     = 9;
    localparam int TAP_W    = 4;
    localparam int CH_W     = 1;
    localparam int CHANNELS = 2;

    localparam int SAMPLE_W = 32;
    localparam int NOISE_W  = 16;
    localparam int DEPTH_W  = 5;
    localparam int CODE_W   = 24;
    localparam int ERR_W    = 18;
    localparam int TPDF_W   = 17;
    localparam int MUL_A_W  = 18;
    localparam int MUL_B_W  = 17;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int ACC_W    = 58;
    localparam int QM_W     = ACC_W - 32;
    localparam int Q_W      = QM_W + 1;
    localparam int XLOW_W   = 34;

    localparam logic [DEPTH_W-1:0] DEPTH_MIN   = 5'd8;
    localparam logic [DEPTH_W-1:0] DEPTH_MAX   = 5'd24;
    localparam logic [DEPTH_W-1:0] DEPTH_RESET = 5'd16;

    // 1/sqrt2 in Q0.16, kept as a positive signed multiplier operand.
    localparam logic signed [MUL_B_W-1:0] INV_SQRT2 = 17'sd46341;

    typedef logic [TAP_W-1:0]          tap_idx_t;
    typedef logic signed [ERR_W-1:0]   err_t;
    typedef logic signed [TPDF_W-1:0]  tpdf_t;
    typedef logic signed [ACC_W-1:0]   acc_t;

    typedef struct packed {
        logic                       init;
        logic                       issue;
        logic                       sub;
        logic signed [MUL_A_W-1:0]  a;
        logic signed [MUL_B_W-1:0]  b;
    } mac_ctrl_t;

    typedef struct packed {
        logic              clear;
        logic              update;
        logic [CH_W-1:0]   ch;
        err_t              err;
        tpdf_t             tpdf;
    } hist_ctrl_t;

    // Noise-shaping filter coefficients in Q4.12, tap 0 is the newest error.
    function automatic logic signed [MUL_B_W-1:0] shape_coef(input tap_idx_t k);
        logic signed [MUL_B_W-1:0] c;
        case (k)
            4'd0:    c = 17'sd9880;
            4'd1:    c = -17'sd13804;
            4'd2:    c = 17'sd16126;
            4'd3:    c = -17'sd17097;
            4'd4:    c = 17'sd13734;
            4'd5:    c = -17'sd9032;
            4'd6:    c = 17'sd5247;
            4'd7:    c = -17'sd2331;
            4'd8:    c = 17'sd347;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/ndq_if.sv =====
interface ndq_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [ndq_pkg::SAMPLE_W-1:0]  sample;
    logic [ndq_pkg::NOISE_W-1:0]          noise_a;
    logic [ndq_pkg::NOISE_W-1:0]          noise_b;
    logic [ndq_pkg::CH_W-1:0]             channel;
    logic                                 restart;

    modport source (output valid, sample, noise_a, noise_b, channel, restart, input ready);
    modport sink   (input valid, sample, noise_a, noise_b, channel, restart, output ready);
endinterface

interface ndq_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [ndq_pkg::CODE_W-1:0]    code;
    logic [ndq_pkg::CH_W-1:0]             out_channel;
    logic                                 clipped;

    modport source (output valid, code, out_channel, clipped, input ready);
    modport sink   (input valid, code, out_channel, clipped, output ready);
endinterface

// ===== rtl/noise_shaped_dither_quantizer.sv =====
// Noise-shaped dither requantizer.
// Input words arrive on the samples channel (valid/ready): a Q1.31 sample, two
// uniform noise values, a channel number and a restart flag. Each input word
// produces exactly one output word on the codes channel: the sample rounded to
// bit_depth bits after high-pass TPDF dither and 9-tap error-feedback shaping,
// saturated to the signed target range, with a clip flag and the channel.
// bit_depth is written through cfg_wr_en/cfg_wr_data, by the user only while the
// block is idle (unchecked by the block); values below 8 act as 8, above 24 as 24.
// One shared multiply-accumulate unit does the work: nine shaping taps and one
// dither product are issued on consecutive cycles, then the drain step empties
// the product register, the round step rounds and the finish step writes the
// result and the shaping state. samples.ready is high only between words.
// The output register lets a new word be accepted while the previous result
// waits; if the receiver still stalls when the next result is due, the block
// holds in its final step until the output register frees up.
// Reset clears the error history, the previous dither values and the output
// valid, and sets bit_depth to 16. No clearing pass is needed after reset.
module noise_shaped_dither_quantizer
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [ndq_pkg::DEPTH_W-1:0]      cfg_wr_data,
    ndq_in_if.sink                           samples,
    ndq_out_if.source                        codes
);

    typedef enum logic [4:0]
    {
        S_IDLE   = 5'b00001,
        S_MAC    = 5'b00010,
        S_DRAIN  = 5'b00100,
        S_ROUND  = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    state_t                               state_reg;
    state_t                               state_next;
    ndq_pkg::tap_idx_t                    tap_reg;
    ndq_pkg::tap_idx_t                    tap_next;
    logic [ndq_pkg::DEPTH_W-1:0]          bit_depth_reg;
    logic [ndq_pkg::DEPTH_W-1:0]          depth_clamped;
    logic [ndq_pkg::DEPTH_W-1:0]          depth_reg;
    logic [ndq_pkg::CH_W-1:0]             ch_reg;
    ndq_pkg::tpdf_t                       tpdf_reg;
    logic [ndq_pkg::QM_W-1:0]             qm_reg;
    logic                                 xneg_reg;
    logic [ndq_pkg::XLOW_W-1:0]           xlow_reg;

    logic                                 out_valid_reg;
    logic signed [ndq_pkg::CODE_W-1:0]    code_reg;
    logic [ndq_pkg::CH_W-1:0]             out_ch_reg;
    logic                                 clip_reg;

    logic                                 accept;
    logic                                 finish;
    ndq_pkg::mac_ctrl_t                   mac_ctrl;
    ndq_pkg::hist_ctrl_t                  hist_ctrl;
    ndq_pkg::acc_t                        init_value;
    ndq_pkg::acc_t                        acc;
    ndq_pkg::err_t                        rd_err;
    ndq_pkg::tpdf_t                       rd_tpdf;
    logic signed [ndq_pkg::MUL_A_W-1:0]   tpdf_diff;
    logic [ndq_pkg::TPDF_W:0]             tpdf_sum;

    logic [ndq_pkg::ACC_W-1:0]            x_mag;
    logic [ndq_pkg::ACC_W-1:0]            x_rnd;
    logic signed [ndq_pkg::Q_W-1:0]       q_val;
    logic signed [ndq_pkg::Q_W-1:0]       q_hi;
    logic signed [ndq_pkg::Q_W-1:0]       q_lo;
    logic signed [ndq_pkg::Q_W-1:0]       q_sat;
    logic                                 q_clip;
    logic [ndq_pkg::XLOW_W-1:0]           err_full;

    // Configuration register and its clamp to the supported word lengths.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_depth_reg <= ndq_pkg::DEPTH_RESET;
        end
        else if (cfg_wr_en)
        begin
            bit_depth_reg <= cfg_wr_data;
        end
    end

    always_comb
    begin
        depth_clamped = bit_depth_reg;
        if (bit_depth_reg < ndq_pkg::DEPTH_MIN)
        begin
            depth_clamped = ndq_pkg::DEPTH_MIN;
        end
        else if (bit_depth_reg > ndq_pkg::DEPTH_MAX)
        begin
            depth_clamped = ndq_pkg::DEPTH_MAX;
        end
    end

    assign samples.ready = (state_reg == S_IDLE);
    assign accept        = samples.valid && samples.ready;
    assign finish        = (state_reg == S_FINISH) && (!out_valid_reg || codes.ready);

    // The working sum starts as the sample scaled to target LSB units, in Q.32.
    assign init_value = ndq_pkg::acc_t'(samples.sample) <<< depth_clamped;

    // Current TPDF value: noise_a + noise_b - 1.0 in Q1.16.
    assign tpdf_sum = {2'b00, samples.noise_a} + {2'b00, samples.noise_b}
                      - (ndq_pkg::TPDF_W + 1)'(65536);

    assign tpdf_diff = ndq_pkg::MUL_A_W'(tpdf_reg) - ndq_pkg::MUL_A_W'(rd_tpdf);

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        tap_next   = tap_reg;
        case (state_reg)
            S_IDLE:
            begin
                tap_next = '0;
                if (accept)
                begin
                    state_next = S_MAC;
                end
            end
            S_MAC:
            begin
                tap_next = tap_reg + 1'b1;
                if (tap_reg == ndq_pkg::tap_idx_t'(ndq_pkg::TAPS))
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (finish)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            tap_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            tap_reg   <= tap_next;
        end
    end

    // Shared multiply-accumulate unit: shaping taps first, then the dither term.
    always_comb
    begin
        mac_ctrl.init  = accept;
        mac_ctrl.issue = (state_reg == S_MAC);
        mac_ctrl.sub   = (tap_reg != ndq_pkg::tap_idx_t'(ndq_pkg::TAPS));
        if (tap_reg == ndq_pkg::tap_idx_t'(ndq_pkg::TAPS))
        begin
            mac_ctrl.a = tpdf_diff;
            mac_ctrl.b = ndq_pkg::INV_SQRT2;
        end
        else
        begin
            mac_ctrl.a = rd_err;
            mac_ctrl.b = ndq_pkg::shape_coef(tap_reg);
        end
    end

    ndq_mac u_mac
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (mac_ctrl),
        .init_value (init_value),
        .acc        (acc)
    );

    // Rounding to nearest with halves away from zero, on the magnitude.
    assign x_mag = acc[ndq_pkg::ACC_W-1] ? (~acc + 1'b1) : acc;
    assign x_rnd = x_mag + ndq_pkg::ACC_W'(64'h8000_0000);

    // Rounded value, signed again, and its saturation to the target range.
    assign q_val = xneg_reg ? -$signed({1'b0, qm_reg}) : $signed({1'b0, qm_reg});
    assign q_hi  = (ndq_pkg::Q_W'(1) <<< (depth_reg - 1'b1)) - 1'b1;
    assign q_lo  = -(ndq_pkg::Q_W'(1) <<< (depth_reg - 1'b1));

    always_comb
    begin
        q_sat  = q_val;
        q_clip = 1'b0;
        if (q_val > q_hi)
        begin
            q_sat  = q_hi;
            q_clip = 1'b1;
        end
        else if (q_val < q_lo)
        begin
            q_sat  = q_lo;
            q_clip = 1'b1;
        end
    end

    // The new error q - x lies within half an LSB, so 34 bits carry it exactly;
    // it is rounded to Q.16 with halves upward.
    assign err_full = {q_val[1:0], 32'h0000_0000} - xlow_reg
                      + ndq_pkg::XLOW_W'(32768);

    always_comb
    begin
        hist_ctrl.clear  = accept && samples.restart;
        hist_ctrl.update = finish;
        hist_ctrl.ch     = accept ? samples.channel : ch_reg;
        hist_ctrl.err    = err_full[ndq_pkg::XLOW_W-1:16];
        hist_ctrl.tpdf   = tpdf_reg;
    end

    ndq_hist u_hist
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (hist_ctrl),
        .rd_ch   (ch_reg),
        .rd_tap  (tap_reg),
        .rd_err  (rd_err),
        .rd_tpdf (rd_tpdf)
    );

    // Per-word working registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ch_reg    <= samples.channel;
            depth_reg <= depth_clamped;
            tpdf_reg  <= tpdf_sum[ndq_pkg::TPDF_W-1:0];
        end
        if (state_reg == S_ROUND)
        begin
            qm_reg   <= x_rnd[ndq_pkg::ACC_W-1:32];
            xneg_reg <= acc[ndq_pkg::ACC_W-1];
            xlow_reg <= acc[ndq_pkg::XLOW_W-1:0];
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (codes.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            code_reg   <= q_sat[ndq_pkg::CODE_W-1:0];
            out_ch_reg <= ch_reg;
            clip_reg   <= q_clip;
        end
    end

    assign codes.valid       = out_valid_reg;
    assign codes.code        = code_reg;
    assign codes.out_channel = out_ch_reg;
    assign codes.clipped     = clip_reg;

endmodule

// ===== rtl/ndq_mac.sv =====
module ndq_mac
(
    input  logic               clk,
    input  logic               rst_n,
    input  ndq_pkg::mac_ctrl_t ctrl,
    input  ndq_pkg::acc_t      init_value,
    output ndq_pkg::acc_t      acc
);

    logic signed [ndq_pkg::PROD_W-1:0] prod_reg;
    logic                              prod_valid_reg;
    logic                              prod_sub_reg;
    ndq_pkg::acc_t                     acc_reg;
    ndq_pkg::acc_t                     prod_ext;

    // Products register before they reach the accumulator.
    always_ff @(posedge clk)
    begin
        if (ctrl.issue)
        begin
            prod_reg     <= ctrl.a * ctrl.b;
            prod_sub_reg <= ctrl.sub;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= ctrl.issue;
        end
    end

    assign prod_ext = ndq_pkg::ACC_W'(prod_reg);

    // Shaping taps enter scaled by 16 and subtracted; the dither term is added.
    always_ff @(posedge clk)
    begin
        if (ctrl.init)
        begin
            acc_reg <= init_value;
        end
        else if (prod_valid_reg)
        begin
            if (prod_sub_reg)
            begin
                acc_reg <= acc_reg - (prod_ext <<< 4);
            end
            else
            begin
                acc_reg <= acc_reg + prod_ext;
            end
        end
    end

    assign acc = acc_reg;

endmodule

// ===== rtl/ndq_hist.sv =====
module ndq_hist
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  ndq_pkg::hist_ctrl_t         ctrl,
    input  logic [ndq_pkg::CH_W-1:0]    rd_ch,
    input  ndq_pkg::tap_idx_t           rd_tap,
    output ndq_pkg::err_t               rd_err,
    output ndq_pkg::tpdf_t              rd_tpdf
);

    ndq_pkg::err_t  err_reg  [ndq_pkg::CHANNELS][ndq_pkg::TAPS];
    ndq_pkg::tpdf_t tpdf_reg [ndq_pkg::CHANNELS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < ndq_pkg::CHANNELS; c++)
            begin
                for (int k = 0; k < ndq_pkg::TAPS; k++)
                begin
                    err_reg[c][k] <= '0;
                end
                tpdf_reg[c] <= '0;
            end
        end
        else if (ctrl.clear)
        begin
            for (int k = 0; k < ndq_pkg::TAPS; k++)
            begin
                err_reg[ctrl.ch][k] <= '0;
            end
            tpdf_reg[ctrl.ch] <= '0;
        end
        else if (ctrl.update)
        begin
            for (int k = ndq_pkg::TAPS - 1; k > 0; k--)
            begin
                err_reg[ctrl.ch][k] <= err_reg[ctrl.ch][k-1];
            end
            err_reg[ctrl.ch][0] <= ctrl.err;
            tpdf_reg[ctrl.ch]   <= ctrl.tpdf;
        end
    end

    always_comb
    begin
        rd_err = '0;
        if (rd_tap < ndq_pkg::tap_idx_t'(ndq_pkg::TAPS))
        begin
            rd_err = err_reg[rd_ch][rd_tap];
        end
    end

    assign rd_tpdf = tpdf_reg[rd_ch];

endmodule

// ===== dv/ndq_checker.sv =====
module ndq_checker
    import ndq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [DEPTH_W-1:0] cfg_wr_data,
    ndq_in_if                  samples,
    ndq_out_if                 codes,
    output int                 failures,
    output int                 pending
);

    // Error-feedback weights in Q4.12, newest error first.
    localparam int FEEDBACK_WEIGHT [TAPS] = '{
        9880, -13804, 16126, -17097, 13734, -9032, 5247, -2331, 347
    };
    localparam longint INV_ROOT2_Q16 = 46341;
    localparam longint ERR_HI        = 131071;
    localparam longint ERR_LO        = -131072;

    typedef struct {
        logic signed [CODE_W-1:0] code;
        logic [CH_W-1:0]          out_channel;
        logic                     clipped;
    } code_word_t;

    logic [DEPTH_W-1:0] word_depth;
    err_t               err_hist [CHANNELS][TAPS];
    tpdf_t              last_tpdf [CHANNELS];
    code_word_t         expected_codes [$];
    int                 fail_count;

    // Requantizes one sample and advances the shaping state of its channel.
    function automatic code_word_t shape_and_quantize(
        input logic signed [SAMPLE_W-1:0] smp,
        input logic [NOISE_W-1:0]         na,
        input logic [NOISE_W-1:0]         nb,
        input logic [CH_W-1:0]            ch,
        input logic                       restart
    );
        code_word_t word;
        int         bits;
        int         idx;
        longint     feedback;
        longint     tpdf_now;
        longint     x;
        longint     mag;
        longint     q;
        longint     err;
        longint     hi;
        longint     lo;

        bits = int'(word_depth);
        if (bits < int'(DEPTH_MIN))
            bits = int'(DEPTH_MIN);
        if (bits > int'(DEPTH_MAX))
            bits = int'(DEPTH_MAX);
        idx = int'(ch) % CHANNELS;

        if (restart)
        begin
            for (int k = 0; k < TAPS; k++)
                err_hist[idx][k] = '0;
            last_tpdf[idx] = '0;
        end

        feedback = 0;
        for (int k = 0; k < TAPS; k++)
            feedback += longint'(FEEDBACK_WEIGHT[k]) * longint'(err_hist[idx][k]);

        tpdf_now = longint'(na) + longint'(nb) - 65536;
        x = longint'(smp) * (longint'(1) << bits) - feedback * 16
            + (tpdf_now - longint'(last_tpdf[idx])) * INV_ROOT2_Q16;
        last_tpdf[idx] = tpdf_t'(tpdf_now);

        // Round to nearest with halves away from zero.
        mag = (x < 0) ? -x : x;
        q = (mag + (longint'(1) << 31)) >>> 32;
        if (x < 0)
            q = -q;

        // The fed-back error comes from the unsaturated value, halves upward.
        err = (q * (longint'(1) << 32) - x + 32768) >>> 16;
        if (err > ERR_HI)
            err = ERR_HI;
        if (err < ERR_LO)
            err = ERR_LO;
        for (int k = TAPS - 1; k > 0; k--)
            err_hist[idx][k] = err_hist[idx][k-1];
        err_hist[idx][0] = err_t'(err);

        hi = (longint'(1) << (bits - 1)) - 1;
        lo = -(longint'(1) << (bits - 1));
        word.clipped = 1'b0;
        if (q > hi)
        begin
            q = hi;
            word.clipped = 1'b1;
        end
        if (q < lo)
        begin
            q = lo;
            word.clipped = 1'b1;
        end
        word.code        = q[CODE_W-1:0];
        word.out_channel = ch;
        return word;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        code_word_t oldest;

        if (!rst_n)
        begin
            word_depth = DEPTH_RESET;
            for (int c = 0; c < CHANNELS; c++)
            begin
                for (int k = 0; k < TAPS; k++)
                    err_hist[c][k] = '0;
                last_tpdf[c] = '0;
            end
            expected_codes.delete();
            fail_count = 0;
            failures <= 0;
            pending  <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                word_depth = cfg_wr_data;

            // Retire first so that a word accepted at this edge is never matched here.
            if (codes.valid && codes.ready)
            begin
                if (expected_codes.size() == 0)
                begin
                    $error("unexpected output word: code %0d, out_channel %0d, clipped %0d",
                           codes.code, codes.out_channel, codes.clipped);
                    fail_count++;
                end
                else
                begin
                    oldest = expected_codes.pop_front();
                    if (codes.code !== oldest.code)
                    begin
                        $error("code: expected %0d, actual %0d", oldest.code, codes.code);
                        fail_count++;
                    end
                    if (codes.out_channel !== oldest.out_channel)
                    begin
                        $error("out_channel: expected %0d, actual %0d",
                               oldest.out_channel, codes.out_channel);
                        fail_count++;
                    end
                    if (codes.clipped !== oldest.clipped)
                    begin
                        $error("clipped: expected %0d, actual %0d",
                               oldest.clipped, codes.clipped);
                        fail_count++;
                    end
                end
            end

            if (samples.valid && samples.ready)
                expected_codes.push_back(shape_and_quantize(samples.sample, samples.noise_a,
                                                            samples.noise_b, samples.channel,
                                                            samples.restart));

            failures <= fail_count;
            pending  <= expected_codes.size();
        end
    end

endmodule

// ===== dv/noise_shaped_dither_quantizer_tb.sv =====
module noise_shaped_dither_quantizer_tb;

    // This module only makes stimulus and gives the verdict. The checker beside the
    // block watches both channels, predicts every output word and counts failures.

    import ndq_pkg::*;

    // A correct block's quiet time without moving a word is bounded by the longest
    // sender gap, the longest receiver stall, the long hold-off and the processing
    // of one word. The limit leaves a wide margin on that.
    localparam int IDLE_LIMIT      = 5000;
    localparam int LONG_HOLD       = 600;
    localparam int SETTLE_CYCLES   = 40;
    localparam int WORDS_PER_PHASE = 93;
    localparam int PHASES          = 10;
    localparam int HOLD_PHASE      = 4;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [DEPTH_W-1:0] cfg_wr_data;

    // Set by the stimulus only: bursty switches all idling off for a stretch, and
    // long_hold asks the receiver for one long stall.
    logic               bursty;
    logic               long_hold;

    int                 failures;
    int                 pending;

    ndq_in_if  samples_ch ();
    ndq_out_if codes_ch ();

    noise_shaped_dither_quantizer i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .samples     (samples_ch),
        .codes       (codes_ch)
    );

    ndq_checker i_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .samples     (samples_ch),
        .codes       (codes_ch),
        .failures    (failures),
        .pending     (pending)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        if (bursty)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 20);
        return $urandom_range(30, 150);
    endfunction

    // Samples cluster where the behavior is interesting: near both ends of full
    // scale (clipping), near zero (dither and shaping dominate) and in between.
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        logic signed [SAMPLE_W-1:0] v;
        case ($urandom_range(0, 5))
            0:       v = $urandom;
            1:       v = 32'sh7FFF_FFFF - $urandom_range(0, 1 << 20);
            2:       v = 32'sh8000_0000 + $urandom_range(0, 1 << 20);
            3:       v = $urandom_range(0, 1 << 17) - (1 << 16);
            default: v = $signed($urandom) >>> $urandom_range(1, 12);
        endcase
        return v;
    endfunction

    function automatic logic [NOISE_W-1:0] pick_noise();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    // Offers one word after a random gap and returns at the edge that accepts it.
    // Valid stays high when the next word follows with no gap.
    task automatic send_word(
        input logic signed [SAMPLE_W-1:0] smp,
        input logic [NOISE_W-1:0]         na,
        input logic [NOISE_W-1:0]         nb,
        input logic [CH_W-1:0]            ch,
        input logic                       restart
    );
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            samples_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        samples_ch.valid   <= 1'b1;
        samples_ch.sample  <= smp;
        samples_ch.noise_a <= na;
        samples_ch.noise_b <= nb;
        samples_ch.channel <= ch;
        samples_ch.restart <= restart;
        @(posedge clk);
        while (!samples_ch.ready)
            @(posedge clk);
    endtask

    // Stops offering and waits until every expected word has come back, then
    // lets the block settle so that it is idle for a register write.
    task automatic drain();
        samples_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_depth(input logic [DEPTH_W-1:0] depth);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= depth;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Receiver: holds ready high until a word is taken, then stalls at random.
    // Once during the run it holds off for a long stretch, which fills the
    // output register and the final stage and so stalls the input side.
    initial
    begin
        int   stall;
        logic held;
        codes_ch.ready = 1'b0;
        held           = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (long_hold && !held)
            begin
                codes_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                held = 1'b1;
            end
            stall = pick_gap();
            if (stall > 0)
            begin
                codes_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            codes_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!codes_ch.valid);
        end
    end

    // Watchdog: ends the run when no word moves on either channel for too long.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((samples_ch.valid && samples_ch.ready) || (codes_ch.valid && codes_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        logic [DEPTH_W-1:0] depth_plan [PHASES];

        depth_plan = '{5'd8, 5'd24, 5'd0, 5'd31, 5'd12, 5'd20, 5'd7, 5'd25, 5'd16, 5'd16};
        depth_plan[PHASES-1] = $urandom_range(0, 31);

        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_wr_data        = DEPTH_RESET;
        bursty             = 1'b0;
        long_hold          = 1'b0;
        samples_ch.valid   = 1'b0;
        samples_ch.sample  = '0;
        samples_ch.noise_a = '0;
        samples_ch.noise_b = '0;
        samples_ch.channel = '0;
        samples_ch.restart = 1'b0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words at the reset depth of 16 bits. With each noise value at
        // one half, so that the two sum to one, the dither and the feedback are
        // both zero after a restart, and a sample of half an output step must
        // round away from zero.
        send_word(32'sh0000_0000, 16'h8000, 16'h8000, 1'b0, 1'b1);
        send_word(32'sh0000_8000, 16'h8000, 16'h8000, 1'b1, 1'b1);
        send_word(-32'sh0000_8000, 16'h8000, 16'h8000, 1'b0, 1'b1);
        send_word(32'sh7FFF_FFFF, 16'h0000, 16'h0000, 1'b0, 1'b0);
        send_word(32'sh8000_0000, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
        send_word(32'sh7FFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
        send_word(32'sh8000_0000, 16'h0000, 16'h0000, 1'b1, 1'b0);
        send_word(32'sh0000_0000, 16'h0000, 16'hFFFF, 1'b0, 1'b0);
        send_word(32'sh0000_0001, 16'hFFFF, 16'h0000, 1'b1, 1'b0);
        send_word(-32'sh0000_0001, 16'h5555, 16'hAAAA, 1'b0, 1'b0);
        send_word(32'sh1234_5678, 16'h0001, 16'h7FFF, 1'b0, 1'b1);
        send_word(32'sh7FFF_8000, 16'hFFFE, 16'h8001, 1'b1, 1'b0);
        send_word(32'shC000_0000, 16'h1234, 16'hEDCB, 1'b1, 1'b1);
        drain();

        // At 24 bits full scale lands right on the edge of the output range, so
        // outward dither pushes the rounded value past it and the code must clip.
        write_depth(5'd24);
        send_word(32'sh7FFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1);
        send_word(32'sh8000_0000, 16'h0000, 16'h0000, 1'b1, 1'b1);
        send_word(32'sh7FFF_FFFF, 16'h0000, 16'h0000, 1'b0, 1'b0);
        send_word(32'sh8000_0000, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
        send_word(32'sh0000_0080, 16'h8000, 16'h8000, 1'b0, 1'b1);
        drain();

        // Depth values outside the meaningful range act as the nearest end.
        write_depth(5'd3);
        send_word(32'sh7FFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1);
        send_word(32'sh8000_0000, 16'h0000, 16'h0000, 1'b1, 1'b1);
        send_word(32'sh0080_0000, 16'h8000, 16'h8000, 1'b0, 1'b1);
        drain();

        // Random phases, each at its own depth and with fresh word content.
        for (int p = 0; p < PHASES; p++)
        begin
            write_depth(depth_plan[p]);
            if (p == HOLD_PHASE)
                long_hold = 1'b1;
            for (int n = 0; n < WORDS_PER_PHASE; n++)
            begin
                if (n % 31 == 0)
                    bursty = ($urandom_range(0, 3) == 0);
                send_word(pick_sample(), pick_noise(), pick_noise(), CH_W'($urandom_range(0, 1)),
                          ($urandom_range(0, 15) == 0));
            end
            bursty = 1'b0;
            drain();
        end

        if (failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
